// ----- hw/rtl/olist_pkg.sv -----
// ----------------------------------------------------------------------------
// olist_pkg: shared types and constants of the ordered list engine
// Command and status codes, cell operations, the cell control word and the
// result record that moves through the output queue.
// ----------------------------------------------------------------------------
package olist_pkg;

	localparam int DATA_W           = 32;
	localparam int POS_W            = 8;
	localparam int DEFAULT_CAPACITY = 16;

	typedef enum logic [2:0] {
		CMD_APPEND    = 3'd0,
		CMD_PREPEND   = 3'd1,
		CMD_INSERT    = 3'd2,
		CMD_DEL_FIRST = 3'd3,
		CMD_DEL_LAST  = 3'd4,
		CMD_DEL_AT    = 3'd5,
		CMD_DEL_VALUE = 3'd6,
		CMD_READ_ALL  = 3'd7
	} cmd_t;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_EMPTY     = 3'd1,
		ST_OUT_RANGE = 3'd2,
		ST_NOT_FOUND = 3'd3,
		ST_FULL      = 3'd4
	} status_t;

	// What every cell of the chain does at each clock edge.
	typedef enum logic [1:0] {
		OP_HOLD,
		OP_INSERT,
		OP_SHIFT,
		OP_ROTATE
	} cell_op_t;

	typedef struct packed {
		cell_op_t            op;
		logic [DATA_W-1:0]   ins_value;
	} cell_ctl_t;

	typedef struct packed {
		status_t             status;
		logic                has_value;
		logic [DATA_W-1:0]   value;
		logic                last;
	} result_t;

endpackage

// ----- hw/rtl/ordered_list_engine.sv -----
// ----------------------------------------------------------------------------
// ordered_list_engine: bounded ordered list of signed 32-bit values
// A chain of cells holds the list; a small sequencer drives it and feeds a
// two-entry result queue.
// ----------------------------------------------------------------------------
// Usage. Requests arrive on in_valid / in_stall with command, item_value and
// position; results leave on out_valid / out_stall with status, has_value,
// result_value and last_of_run. A request or result moves at a rising edge
// where valid is high and stall is low.
// Timing. Append, prepend and insert update the chain at the accepting edge
// and their single result is registered into the result queue at that edge;
// a new request may follow while the skid entry stays free. Deletes that go
// ahead rotate the ring once around, with the result pushed at the last step.
// Read all also rotates the ring and emits one result per cycle while the
// skid entry is free. An insert on a full list, a delete or read all on an
// empty list, or a bad position answers with one status result only.
// Stalls. Results sit in an output register backed by a skid entry, so one
// further request is taken while a result waits. When both are held, in_stall
// rises and a read all pauses its ring; in_stall is high during any rotation.
// Reset clears the entry count, the sequencer and the queue; cell contents
// are not cleared and are never read before they are written.
// ----------------------------------------------------------------------------
module ordered_list_engine #(
	parameter int CAPACITY = olist_pkg::DEFAULT_CAPACITY
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  olist_pkg::cmd_t                      command,
	input  logic signed [olist_pkg::DATA_W-1:0]  item_value,
	input  logic [olist_pkg::POS_W-1:0]          position,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output olist_pkg::status_t                   status,
	output logic                                 has_value,
	output logic signed [olist_pkg::DATA_W-1:0]  result_value,
	output logic                                 last_of_run
);
	import olist_pkg::*;

	localparam int IDX_W = $clog2(CAPACITY);
	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int CMP_W = POS_W + 1;

	typedef enum logic [1:0] {
		S_IDLE,
		S_READ,
		S_SCAN
	} state_t;

	state_t              state_q;
	logic [CNT_W-1:0]    count_q;
	logic [IDX_W-1:0]    step_q;
	logic [IDX_W-1:0]    end_idx_q;
	logic [IDX_W-1:0]    pos_q;
	logic [DATA_W-1:0]   val_q;
	logic [DATA_W-1:0]   found_val_q;
	logic                by_value_q;
	logic                found_q;
	result_t             out_q;
	logic                out_valid_q;
	result_t             skid_q;
	logic                skid_valid_q;

	logic [DATA_W-1:0]   cell_value [CAPACITY];
	cell_ctl_t           ctl;
	logic [IDX_W-1:0]    ins_pos;
	logic [IDX_W-1:0]    last_idx;
	logic [CNT_W-1:0]    cnt_dec;
	logic                accept;
	logic                pop;
	logic                room;
	logic                push;
	result_t             push_data;
	logic                full;
	logic                empty;
	logic                match;
	logic                go_scan;
	logic                go_read;
	logic [IDX_W-1:0]    scan_pos;

	// ------------------------------------------------------------------
	// Cell chain. Each cell sees its two neighbors; cell 0 also drives the
	// wrap bus that closes the ring at the tail during a rotation.
	// ------------------------------------------------------------------
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic [DATA_W-1:0] left_v;
		logic [DATA_W-1:0] right_v;
		if (i == 0) begin : g_head
			assign left_v = '0;
		end else begin : g_mid_l
			assign left_v = cell_value[i-1];
		end
		if (i == CAPACITY - 1) begin : g_tail
			assign right_v = cell_value[i];
		end else begin : g_mid_r
			assign right_v = cell_value[i+1];
		end
		olist_cell #(
			.CAPACITY (CAPACITY),
			.INDEX    (i)
		) u_cell (
			.clk         (clk),
			.ctl         (ctl),
			.ins_pos     (ins_pos),
			.last_idx    (last_idx),
			.left_value  (left_v),
			.right_value (right_v),
			.wrap_value  (cell_value[0]),
			.value       (cell_value[i])
		);
	end

	// ------------------------------------------------------------------
	// Sequencer decisions.
	// ------------------------------------------------------------------
	assign cnt_dec  = count_q - CNT_W'(1);
	assign last_idx = cnt_dec[IDX_W-1:0];
	assign full     = (count_q == CNT_W'(CAPACITY));
	assign empty    = (count_q == '0);
	assign room     = !skid_valid_q;
	assign pop      = out_valid_q && !out_stall;
	assign in_stall = (state_q != S_IDLE) || skid_valid_q;
	assign accept   = in_valid && !in_stall;

	// During a scan the head of the ring is the entry under test; the first
	// hit is dropped by a plain left shift instead of a rotation.
	assign match = !found_q && (by_value_q ? (cell_value[0] == val_q) : (step_q == pos_q));

	always_comb begin
		ctl.op        = OP_HOLD;
		ctl.ins_value = item_value;
		ins_pos       = '0;
		push          = 1'b0;
		push_data     = '{status: ST_OK, has_value: 1'b0, value: '0, last: 1'b1};
		go_scan       = 1'b0;
		go_read       = 1'b0;
		scan_pos      = '0;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					unique case (command)
						CMD_APPEND, CMD_PREPEND, CMD_INSERT: begin
							push = 1'b1;
							if (full) begin
								push_data.status = ST_FULL;
							end else if (command == CMD_INSERT &&
									CMP_W'(position) > CMP_W'(count_q)) begin
								push_data.status = ST_OUT_RANGE;
							end else begin
								ctl.op = OP_INSERT;
								if (command == CMD_APPEND) begin
									ins_pos = count_q[IDX_W-1:0];
								end else if (command == CMD_INSERT) begin
									ins_pos = position[IDX_W-1:0];
								end
							end
						end
						CMD_DEL_FIRST, CMD_DEL_LAST, CMD_DEL_AT, CMD_DEL_VALUE: begin
							if (empty) begin
								push             = 1'b1;
								push_data.status = ST_EMPTY;
							end else if (command == CMD_DEL_AT &&
									CMP_W'(position) >= CMP_W'(count_q)) begin
								push             = 1'b1;
								push_data.status = ST_OUT_RANGE;
							end else begin
								go_scan = 1'b1;
								if (command == CMD_DEL_LAST) begin
									scan_pos = last_idx;
								end else if (command == CMD_DEL_AT) begin
									scan_pos = position[IDX_W-1:0];
								end
							end
						end
						CMD_READ_ALL: begin
							if (empty) begin
								push             = 1'b1;
								push_data.status = ST_EMPTY;
							end else begin
								go_read = 1'b1;
							end
						end
						default: begin
							push = 1'b0;
						end
					endcase
				end
			end
			S_READ: begin
				if (room) begin
					ctl.op              = OP_ROTATE;
					push                = 1'b1;
					push_data.has_value = 1'b1;
					push_data.value     = cell_value[0];
					push_data.last      = (step_q == end_idx_q);
				end
			end
			S_SCAN: begin
				ctl.op = match ? OP_SHIFT : OP_ROTATE;
				if (step_q == end_idx_q) begin
					push = 1'b1;
					if (match || found_q) begin
						push_data.has_value = 1'b1;
						push_data.value     = match ? cell_value[0] : found_val_q;
					end else begin
						push_data.status = ST_NOT_FOUND;
					end
				end
			end
			default: begin
				ctl.op = OP_HOLD;
			end
		endcase
	end

	// ------------------------------------------------------------------
	// State, entry count and result queue.
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			count_q      <= '0;
			step_q       <= '0;
			found_q      <= 1'b0;
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			// Result queue: output register in front, skid entry behind it.
			if (skid_valid_q) begin
				if (pop) begin
					out_q        <= skid_q;
					skid_valid_q <= 1'b0;
				end
			end else if (!out_valid_q || pop) begin
				out_q       <= push_data;
				out_valid_q <= push;
			end else if (push) begin
				skid_q       <= push_data;
				skid_valid_q <= 1'b1;
			end

			unique case (state_q)
				S_IDLE: begin
					if (ctl.op == OP_INSERT) begin
						count_q <= count_q + CNT_W'(1);
					end
					if (go_scan || go_read) begin
						step_q     <= '0;
						end_idx_q  <= last_idx;
						found_q    <= 1'b0;
						pos_q      <= scan_pos;
						val_q      <= item_value;
						by_value_q <= (command == CMD_DEL_VALUE);
						state_q    <= go_scan ? S_SCAN : S_READ;
					end
				end
				S_READ: begin
					if (room) begin
						step_q <= step_q + IDX_W'(1);
						if (step_q == end_idx_q) begin
							state_q <= S_IDLE;
						end
					end
				end
				S_SCAN: begin
					step_q <= step_q + IDX_W'(1);
					if (match) begin
						found_q     <= 1'b1;
						found_val_q <= cell_value[0];
						count_q     <= cnt_dec;
					end
					if (step_q == end_idx_q) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_valid    = out_valid_q;
	assign status       = out_q.status;
	assign has_value    = out_q.has_value;
	assign result_value = out_q.value;
	assign last_of_run  = out_q.last;

	// ------------------------------------------------------------------
	// Assertions.
	// ------------------------------------------------------------------
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(CAPACITY))
		else $error("entry count above capacity");

	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid entry holds a result while the output register is empty");

	a_busy_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE) |-> in_stall)
		else $error("request taken while a command is in progress");

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !skid_valid_q)
		else $error("result pushed into a full queue");

	a_scan_one_drop: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN && found_q) |-> !match)
		else $error("second entry dropped in one delete");

endmodule

// ----- hw/rtl/olist_cell.sv -----
// ----------------------------------------------------------------------------
// olist_cell: one storage cell of the list chain
// Holds one entry and takes a new value from its left or right neighbor, the
// insert value or the wrap bus, as the shared control word says.
// ----------------------------------------------------------------------------
module olist_cell #(
	parameter int CAPACITY = olist_pkg::DEFAULT_CAPACITY,
	parameter int INDEX    = 0
) (
	input  logic                             clk,
	input  olist_pkg::cell_ctl_t             ctl,
	input  logic [$clog2(CAPACITY)-1:0]      ins_pos,
	input  logic [$clog2(CAPACITY)-1:0]      last_idx,
	input  logic [olist_pkg::DATA_W-1:0]     left_value,
	input  logic [olist_pkg::DATA_W-1:0]     right_value,
	input  logic [olist_pkg::DATA_W-1:0]     wrap_value,
	output logic [olist_pkg::DATA_W-1:0]     value
);
	import olist_pkg::*;

	localparam int IDX_W = $clog2(CAPACITY);
	localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

	logic [DATA_W-1:0] value_q;

	always_ff @(posedge clk) begin
		unique case (ctl.op)
			OP_HOLD: begin
				value_q <= value_q;
			end
			OP_INSERT: begin
				if (MY_IDX == ins_pos) begin
					value_q <= ctl.ins_value;
				end else if (MY_IDX > ins_pos) begin
					value_q <= left_value;
				end
			end
			OP_SHIFT: begin
				value_q <= right_value;
			end
			OP_ROTATE: begin
				// The cell at the tail of the list closes the ring.
				value_q <= (MY_IDX == last_idx) ? wrap_value : right_value;
			end
			default: begin
				value_q <= value_q;
			end
		endcase
	end

	assign value = value_q;

endmodule
